>>> rtl/dynamic_priority_scheduler_macros.svh
// assertion macros shared by the scheduler checker
// no dependencies; take in with a bare include
`ifndef DYNAMIC_PRIORITY_SCHEDULER_MACROS_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, disabled during reset
`define DPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

>>> rtl/dps_pkg.sv
// types shared by the priority scheduler cells and control
// no dependencies
`timescale 1ns / 1ps

package dps_pkg;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] prio;
    logic [15:0]        ptime;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PUSH,
    ST_RESP
  } state_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic signed [15:0] PRIO_FLOOR = 16'sh8000;

endpackage

>>> rtl/dps_cell.sv
// one slot of the ordered process queue
// depends on dps_pkg
`timescale 1ns / 1ps

module dps_cell (
  input  logic               clk,
  input  dps_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_ins,
  input  dps_pkg::entry_t    left_entry,
  input  dps_pkg::entry_t    right_entry,
  output logic               ins,
  output dps_pkg::entry_t    entry
);
  import dps_pkg::*;

  // new item belongs at or before this slot
  assign ins = !occupied || (ctl.item.prio > entry.prio);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_PUSH: begin
        if (ins) begin
          entry <= left_ins ? left_entry : ctl.item;
        end
      end
      OP_POP: begin
        entry <= right_entry;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

>>> rtl/dynamic_priority_scheduler.sv
// top level of the dynamic priority scheduler: control and cell row
// depends on dps_pkg and dps_cell
`timescale 1ns / 1ps

// Usage
// A command beat is taken when start is high and busy is low. req_type
// selects a load (proc_id, proc_priority, proc_time) or a scheduling tick.
// Every command gives exactly one result, shown for one cycle while
// result_valid is high; the receiver cannot stall it.
// Steps from an accepted beat to the next possible accept:
//   load into a non-full table       insert step, result
//   tick that runs a process         pop, reinsert, result
//   rejected load or idle tick       result only
// A finished process skips the reinsert step.
// The queue is a row of MAX_PROCS cells; each insert or pop moves the
// whole row in a single step, every cell taking its neighbour's entry
// where needed and, on an insert, comparing the new priority to its own.
// Reset empties the table and clears the tick count.
module dynamic_priority_scheduler #(
  parameter int MAX_PROCS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  proc_id,
  input  logic signed [15:0] proc_priority,
  input  logic [15:0] proc_time,
  output logic        result_valid,
  output logic        ran,
  output logic [7:0]  run_id,
  output logic        run_done,
  output logic [31:0] tick_count,
  output logic        queue_empty,
  output logic        load_rejected
);
  import dps_pkg::*;

  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  entry_t            item;
  cell_ctl_t         ctl;
  entry_t            entries [MAX_PROCS];
  logic              ins     [MAX_PROCS];

  logic   full;
  logic   empty;
  entry_t head;

  assign full  = (count == CNT_W'(MAX_PROCS));
  assign empty = (count == '0);
  assign head  = entries[0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_LOAD) begin
            state_next = full ? ST_RESP : ST_PUSH;
          end else begin
            state_next = empty ? ST_RESP : ST_POP;
          end
        end
      end
      ST_POP: begin
        state_next = (head.ptime <= 16'd1) ? ST_RESP : ST_PUSH;
      end
      ST_PUSH: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and cell commands
  always_comb begin
    busy         = 1'b1;
    result_valid = 1'b0;
    ctl.op       = OP_HOLD;
    ctl.item     = item;
    case (state)
      ST_IDLE: busy         = 1'b0;
      ST_POP:  ctl.op       = OP_POP;
      ST_PUSH: ctl.op       = OP_PUSH;
      ST_RESP: result_valid = 1'b1;
      default: busy         = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      tick_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_POP:  begin
          count      <= count - CNT_W'(1);
          tick_count <= tick_count + 32'd1;
        end
        ST_PUSH: count <= count + CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // result fields and the item waiting for insertion
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          ran           <= 1'b0;
          run_id        <= '0;
          run_done      <= 1'b0;
          load_rejected <= (req_type == REQ_LOAD) && full;
          item.id       <= proc_id;
          item.prio     <= proc_priority;
          item.ptime    <= proc_time;
        end
      end
      ST_POP: begin
        ran        <= 1'b1;
        run_id     <= head.id;
        run_done   <= (head.ptime <= 16'd1);
        item.id    <= head.id;
        // priority saturates at its floor
        item.prio  <= (head.prio == PRIO_FLOOR) ? head.prio : head.prio - 16'sd1;
        item.ptime <= head.ptime - 16'd1;
      end
      default: begin
        item <= item;
      end
    endcase
  end

  assign queue_empty = empty;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_i;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_i = ins[i-1];
    end

    if (i == MAX_PROCS - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    dps_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count),
      .left_ins    (left_i),
      .left_entry  (left_e),
      .right_entry (right_e),
      .ins         (ins[i]),
      .entry       (entries[i])
    );
  end

endmodule

>>> rtl/dps_checker.sv
// port-level checks for the dynamic priority scheduler, bound to the top
// depends on dynamic_priority_scheduler_macros.svh
`timescale 1ns / 1ps
`include "dynamic_priority_scheduler_macros.svh"

module dps_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic ran,
  input logic run_done,
  input logic load_rejected
);

  // a result is one cycle wide and frees the command side after it
  `DPS_ASSERT_NEXT(a_one_cycle_result, clk, rst, result_valid, !result_valid && !busy)
  // an accepted beat always makes the block busy
  `DPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy)
  // a finished process must have run
  `DPS_ASSERT_NOW(a_done_needs_run, clk, rst, result_valid && run_done, ran)
  // a tick that ran never reports a rejected load
  `DPS_ASSERT_NOW(a_run_not_rejected, clk, rst, result_valid && ran, !load_rejected)

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (.*);

>>> bench/sched_checker.sv
// scoreboard for the dynamic priority scheduler: predicts every result beat and checks it
// depends on dps_pkg; watches the command and result ports of the block
`timescale 1ns / 1ps

module sched_checker #(
  parameter int MAX_PROCS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               req_type,
  input  logic [7:0]         proc_id,
  input  logic signed [15:0] proc_priority,
  input  logic [15:0]        proc_time,
  input  logic               result_valid,
  input  logic               ran,
  input  logic [7:0]         run_id,
  input  logic               run_done,
  input  logic [31:0]        tick_count,
  input  logic               queue_empty,
  input  logic               load_rejected,
  output int                 fail_count,
  output int                 outstanding
);
  import dps_pkg::*;

  typedef struct packed {
    logic        ran;
    logic [7:0]  id;
    logic        done;
    logic [31:0] ticks;
    logic        empty;
    logic        rejected;
  } sched_result_t;

  // shadow of the ordered process table
  entry_t        slots [MAX_PROCS];
  int unsigned   used;
  logic [31:0]   ticks_run;
  sched_result_t results_due [$];

  // goes behind every entry of higher or equal priority
  function automatic void place(entry_t e);
    int unsigned pos;
    bit          found;
    pos   = used;
    found = 0;
    for (int unsigned i = 0; i < used; i++) begin
      if (!found && $signed(e.prio) > $signed(slots[i].prio)) begin
        pos   = i;
        found = 1;
      end
    end
    for (int unsigned i = used; i > pos; i--) slots[i] = slots[i - 1];
    slots[pos] = e;
    used++;
  endfunction

  function automatic sched_result_t schedule_beat(logic req, entry_t e);
    sched_result_t r;
    entry_t        head;
    r = '0;
    if (req == REQ_LOAD) begin
      if (used >= MAX_PROCS) r.rejected = 1'b1;
      else place(e);
    end else if (used > 0) begin
      head = slots[0];
      for (int unsigned i = 1; i < used; i++) slots[i - 1] = slots[i];
      used--;
      if (head.prio != PRIO_FLOOR) head.prio = head.prio - 16'sd1;
      ticks_run = ticks_run + 32'd1;
      r.ran = 1'b1;
      r.id  = head.id;
      if (head.ptime <= 16'd1) begin
        r.done = 1'b1;
      end else begin
        head.ptime = head.ptime - 16'd1;
        place(head);
      end
    end
    r.ticks = ticks_run;
    r.empty = (used == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    sched_result_t want;
    entry_t        cmd;
    if (rst) begin
      used       = 0;
      ticks_run  = '0;
      fail_count = 0;
      results_due.delete();
    end else begin
      if (result_valid) begin
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected, run_id %0d", run_id);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("ran", want.ran, ran);
          check_field("run_id", want.id, run_id);
          check_field("run_done", want.done, run_done);
          check_field("tick_count", want.ticks, tick_count);
          check_field("queue_empty", want.empty, queue_empty);
          check_field("load_rejected", want.rejected, load_rejected);
        end
      end
      if (start && !busy) begin
        cmd.id    = proc_id;
        cmd.prio  = proc_priority;
        cmd.ptime = proc_time;
        results_due = {results_due, schedule_beat(req_type, cmd)};
      end
    end
    outstanding <= results_due.size();
  end

endmodule

>>> bench/testbench.sv
// top of the scheduler bench: clock, reset, command stimulus and the verdict
// depends on dps_pkg, dynamic_priority_scheduler and sched_checker
`timescale 1ns / 1ps

module testbench;
  import dps_pkg::*;

  localparam int RANDOM_BEATS = 550;
  localparam int QUIET_TAIL   = 80;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               req_type;
  logic [7:0]         proc_id;
  logic signed [15:0] proc_priority;
  logic [15:0]        proc_time;
  logic               result_valid;
  logic               ran;
  logic [7:0]         run_id;
  logic               run_done;
  logic [31:0]        tick_count;
  logic               queue_empty;
  logic               load_rejected;
  int                 fail_count;
  int                 outstanding;

  dynamic_priority_scheduler #(.MAX_PROCS(8)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .proc_id(proc_id), .proc_priority(proc_priority),
    .proc_time(proc_time), .result_valid(result_valid), .ran(ran),
    .run_id(run_id), .run_done(run_done), .tick_count(tick_count),
    .queue_empty(queue_empty), .load_rejected(load_rejected)
  );

  sched_checker #(.MAX_PROCS(8)) u_scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .proc_id(proc_id), .proc_priority(proc_priority),
    .proc_time(proc_time), .result_valid(result_valid), .ran(ran),
    .run_id(run_id), .run_done(run_done), .tick_count(tick_count),
    .queue_empty(queue_empty), .load_rejected(load_rejected),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dynamic_priority_scheduler verification failed");
    $finish;
  end

  // holds the beat until the block takes it; called just after a rising edge
  task automatic issue(logic req, logic [7:0] id, logic signed [15:0] prio,
                       logic [15:0] t);
    req_type      <= req;
    proc_id       <= id;
    proc_priority <= prio;
    proc_time     <= t;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load(logic [7:0] id, logic signed [15:0] prio, logic [15:0] t);
    issue(REQ_LOAD, id, prio, t);
  endtask

  task automatic tick();
    issue(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // outstanding is a registered copy of the queue size, so look only after the next edge
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly a few values so ties are common, with both ends and the odd wide one
  function automatic logic signed [15:0] pick_priority();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 16'($signed($urandom_range(0, 4)) - 2);
    if (roll < 70) return PRIO_FLOOR + 16'($urandom_range(0, 3));
    if (roll < 80) return 16'sh7fff - 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int  phase_left;
    int  load_pct;
    bit  gaps_on;
    bit  long_used;
    int  roll;
    logic [15:0] t;

    rst           = 1'b1;
    start         = 1'b0;
    req_type      = REQ_LOAD;
    proc_id       = '0;
    proc_priority = '0;
    proc_time     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick, field extremes, ties, zero time, full table
    tick();
    load(8'hff, 16'sh7fff, 16'd0);
    load(8'h00, PRIO_FLOOR, 16'hffff);
    load(8'h5a, 16'sd0, 16'd1);
    load(8'ha5, 16'sd0, 16'd3);
    load(8'h3c, PRIO_FLOOR, 16'd2);
    tick();
    tick();
    tick();
    load(8'h01, 16'sd100, 16'd2);
    load(8'h02, 16'sd100, 16'd2);
    load(8'h03, -16'sd1, 16'd2);
    load(8'h04, 16'sh7fff, 16'd2);
    load(8'h05, 16'sd5, 16'd2);
    load(8'h77, 16'sd9, 16'd4);
    repeat (4) tick();
    drain_results();

    phase_left = 0;
    load_pct   = 50;
    gaps_on    = 1'b0;
    long_used  = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // alternate filling and draining stretches so the table empties and fills
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        load_pct   = (load_pct > 50) ? 15 : 75;
        gaps_on    = ($urandom_range(0, 2) != 0);
      end
      phase_left--;
      if (n == RANDOM_BEATS / 2) drain_results();

      if ($urandom_range(0, 99) < load_pct) begin
        roll = $urandom_range(0, 99);
        if (roll < 10)      t = 16'd0;
        else if (roll < 70) t = 16'($urandom_range(1, 4));
        else if (roll < 98 || long_used) t = 16'($urandom_range(5, 12));
        else begin
          t         = 16'($urandom);
          long_used = 1'b1;
        end
        load(8'($urandom), pick_priority(), t);
      end else begin
        tick();
      end

      if (gaps_on && n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 13));
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("dynamic_priority_scheduler verification clean");
    else
      $display("dynamic_priority_scheduler verification failed");
    $finish;
  end

endmodule
